[src/counting_semaphore_waiter_fifo_macros.svh]
// Assertion macros for the checker file of the semaphore block.
// Depends on nothing; included by bare file name.
`ifndef COUNTING_SEMAPHORE_WAITER_FIFO_MACROS_SVH
`define COUNTING_SEMAPHORE_WAITER_FIFO_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore check failed");

`endif

[src/csw_pkg.sv]
// Package for the counting semaphore with FIFO wait queue.
// Holds request/result transaction types, codes and default sizes; no dependencies.
package csw_pkg;

    localparam int WAIT_DEPTH_DEF     = 16;
    localparam int THREAD_ID_BITS_DEF = 8;
    localparam int COUNT_W            = 18;
    localparam int CFG_W              = 16;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sh1FFFF;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_POLL   = 2'd1,
        MODE_SIGNAL = 2'd2,
        MODE_CLOSE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BLOCKED     = 3'd1,
        ST_WOULD_BLOCK = 3'd2,
        ST_CLOSED      = 3'd3,
        ST_RELEASED    = 3'd4,
        ST_FULL        = 3'd5
    } status_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] thread_id;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] released_thread;
        logic       last;
    } rsp_t;

    typedef enum logic [1:0] {
        CSW_IDLE  = 2'd0,
        CSW_EXEC  = 2'd1,
        CSW_DRAIN = 2'd2
    } csw_state_t;

    // Queue commands from the controller
    typedef struct packed {
        logic push;   // write push id at tail
        logic peek;   // read the entry at head
        logic pop;    // retire head, read the following entry
    } q_cmd_t;

    // Queue fill status toward the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
    } q_stat_t;

endpackage

[src/csw_wait_queue.sv]
// Wait queue of blocked thread ids: synchronous memory plus head/tail/fill pointers.
// Depends on csw_pkg (q_cmd_t, q_stat_t).
module csw_wait_queue #(
    parameter int WAIT_DEPTH     = csw_pkg::WAIT_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csw_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  csw_pkg::q_cmd_t           cmd,
    input  logic [THREAD_ID_BITS-1:0] push_id,
    output logic [THREAD_ID_BITS-1:0] head_id,
    output csw_pkg::q_stat_t          stat
);
    import csw_pkg::*;

    localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int OCC_W = $clog2(WAIT_DEPTH + 1);

    logic [THREAD_ID_BITS-1:0] mem [WAIT_DEPTH];
    logic [THREAD_ID_BITS-1:0] rdata_reg;

    logic [PTR_W-1:0] head_reg, head_next, head_inc;
    logic [PTR_W-1:0] tail_reg, tail_next, tail_inc;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [PTR_W-1:0] rd_addr;
    logic             rd_en;

    // Wrap pointers at the queue depth
    assign head_inc = (head_reg == PTR_W'(WAIT_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc = (tail_reg == PTR_W'(WAIT_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);

    // Advance pointers and fill count
    always_comb
    begin
        head_next = cmd.pop  ? head_inc : head_reg;
        tail_next = cmd.push ? tail_inc : tail_reg;
        case ({cmd.push, cmd.pop})
            2'b10:   occ_next = occ_reg + OCC_W'(1);
            2'b01:   occ_next = occ_reg - OCC_W'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
        end
    end

    // Read at head on peek, prefetch the next entry on pop
    assign rd_en   = cmd.peek | cmd.pop;
    assign rd_addr = cmd.pop ? head_inc : head_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[tail_reg] <= push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign head_id       = rdata_reg;
    assign stat.empty    = (occ_reg == '0);
    assign stat.full     = (occ_reg == OCC_W'(WAIT_DEPTH));
    assign stat.one_left = (occ_reg == OCC_W'(1));

endmodule

[src/csw_ctrl.sv]
// Request sequencer: count, closed flag, request latch and result register.
// Depends on csw_pkg; drives csw_wait_queue through q_cmd_t.
module csw_ctrl #(
    parameter int THREAD_ID_BITS = csw_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  csw_pkg::req_t             request,
    output logic                      result_valid,
    output csw_pkg::rsp_t             result,
    input  logic                      cfg_we,
    input  logic [csw_pkg::CFG_W-1:0] cfg_wdata,
    output csw_pkg::q_cmd_t           q_cmd,
    output logic [THREAD_ID_BITS-1:0] q_push_id,
    input  logic [THREAD_ID_BITS-1:0] q_head_id,
    input  csw_pkg::q_stat_t          q_stat
);
    import csw_pkg::*;

    csw_state_t state_reg, state_next;
    req_t       req_reg;
    logic signed [COUNT_W-1:0] count_reg, count_next, count_inc;
    logic       closed_reg, closed_next;
    rsp_t       result_reg, result_next;
    logic       result_valid_reg, result_valid_next;
    logic       accept;
    logic       drain_go;
    logic       drain_more;

    assign accept = start && (state_reg == CSW_IDLE);
    assign busy   = (state_reg != CSW_IDLE);

    // Saturating increment for signal
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + COUNT_W'(1) : count_reg;

    // Release path needed: signal with waiters left blocked, or close with waiters
    assign drain_go = !closed_reg && !q_stat.empty &&
                      ((req_reg.mode == MODE_CLOSE) ||
                       ((req_reg.mode == MODE_SIGNAL) && (count_inc <= 0)));
    assign drain_more = (req_reg.mode == MODE_CLOSE) && !q_stat.one_left;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CSW_IDLE:  state_next = accept ? CSW_EXEC : CSW_IDLE;
            CSW_EXEC:  state_next = drain_go ? CSW_DRAIN : CSW_IDLE;
            CSW_DRAIN: state_next = drain_more ? CSW_DRAIN : CSW_IDLE;
            default:   state_next = CSW_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        count_next        = count_reg;
        closed_next       = closed_reg;
        q_cmd             = '0;
        result_next       = '{status: ST_OK, released_thread: 8'd0, last: 1'b1};
        result_valid_next = 1'b0;
        unique case (state_reg)
            CSW_IDLE:
            begin
                result_valid_next = 1'b0;
            end
            CSW_EXEC:
            begin
                result_valid_next = !drain_go;
                if (closed_reg)
                begin
                    result_next.status = ST_CLOSED;
                end
                else
                begin
                    unique case (req_reg.mode)
                        MODE_WAIT:
                        begin
                            if (count_reg > 0)
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                            else if (q_stat.full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next         = count_reg - COUNT_W'(1);
                                q_cmd.push         = 1'b1;
                                result_next.status = ST_BLOCKED;
                            end
                        end
                        MODE_POLL:
                        begin
                            if (count_reg > 0)
                            begin
                                count_next = count_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                result_next.status = ST_WOULD_BLOCK;
                            end
                        end
                        MODE_SIGNAL:
                        begin
                            count_next = count_inc;
                            q_cmd.peek = drain_go;
                        end
                        MODE_CLOSE:
                        begin
                            closed_next = 1'b1;
                            q_cmd.peek  = drain_go;
                        end
                        default:
                        begin
                            result_next.status = ST_OK;
                        end
                    endcase
                end
            end
            CSW_DRAIN:
            begin
                // Post the head entry and retire it
                q_cmd.pop                   = 1'b1;
                result_valid_next           = 1'b1;
                result_next.status          = ST_RELEASED;
                result_next.released_thread = 8'(q_head_id);
                result_next.last            = !drain_more;
            end
            default:
            begin
                result_valid_next = 1'b0;
            end
        endcase
    end

    assign q_push_id = THREAD_ID_BITS'(req_reg.thread_id);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= CSW_IDLE;
            count_reg        <= '0;
            closed_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            closed_reg       <= closed_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                count_reg <= signed'(COUNT_W'(cfg_wdata));
            end
            else
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload: request latch and result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[src/counting_semaphore_waiter_fifo.sv]
// Top level of the counting semaphore with FIFO wait queue.
// Depends on csw_pkg, csw_ctrl and csw_wait_queue.
//
// One request is taken at a time: busy rises at the edge that takes start
// and stays high until the request's last result is posted. A wait, a
// poll, a signal that releases nobody, a close with an empty queue and
// any request after close go from the execute state straight back to idle,
// with the result strobe posted as busy falls. A signal that releases a
// waiter also passes through the drain state, because the waiter id comes
// out of the single read port of the wait-queue memory as a registered read
// of its address. A close with N waiters stays in the drain state and posts
// N releases on consecutive cycles, oldest first, last set on the final one.
// The receiver cannot stall: each result is valid for exactly one cycle and
// must be taken then. Write the initial count only while busy is low and no
// result is pending; the write loads the count at once.
module counting_semaphore_waiter_fifo #(
    parameter int WAIT_DEPTH     = csw_pkg::WAIT_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csw_pkg::THREAD_ID_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  csw_pkg::req_t             request,
    output logic                      result_valid,
    output csw_pkg::rsp_t             result,
    input  logic                      cfg_we,
    input  logic [csw_pkg::CFG_W-1:0] cfg_wdata
);
    import csw_pkg::*;

    q_cmd_t                    q_cmd;
    q_stat_t                   q_stat;
    logic [THREAD_ID_BITS-1:0] q_push_id;
    logic [THREAD_ID_BITS-1:0] q_head_id;

    // Sequence requests and hold the count
    csw_ctrl #(
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_cmd        (q_cmd),
        .q_push_id    (q_push_id),
        .q_head_id    (q_head_id),
        .q_stat       (q_stat)
    );

    // Hold blocked thread ids in arrival order
    csw_wait_queue #(
        .WAIT_DEPTH     (WAIT_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (q_cmd),
        .push_id (q_push_id),
        .head_id (q_head_id),
        .stat    (q_stat)
    );

endmodule

[src/counting_semaphore_waiter_fifo_chk.sv]
// Port-level checker for the semaphore block, bound to the top level.
// Depends on csw_pkg and counting_semaphore_waiter_fifo_macros.svh.
`include "counting_semaphore_waiter_fifo_macros.svh"

module counting_semaphore_waiter_fifo_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          result_valid,
    input csw_pkg::rsp_t result
);
    import csw_pkg::*;

    // An accepted transaction keeps the block busy in the following cycle
    `CSW_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // A release burst continues every cycle until last
    `CSW_ASSERT_NEXT(a_burst_gapless, clk, rst_n, result_valid && !result.last, result_valid)

    // The cycle after a final result never carries another one
    `CSW_ASSERT_NEXT(a_last_gap, clk, rst_n, result_valid && result.last, !result_valid)

    // Only releases carry a thread id
    `CSW_ASSERT_NOW(a_id_zero, clk, rst_n,
        result_valid && (result.status != ST_RELEASED), result.released_thread == 8'd0)

endmodule

bind counting_semaphore_waiter_fifo counting_semaphore_waiter_fifo_chk u_chk (.*);
